// ----- hw/rtl/lru_pkg.sv -----
package lru_pkg;

  // width of the frame count register
  localparam int CFG_W = 4;
  // frame count after reset
  localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;
  // width of the frame index result field
  localparam int FRAME_IDX_W = 3;
  // width of the fault counter
  localparam int FAULT_W = 32;

  // back end status seen by the top level
  typedef struct packed {
    logic               busy;
    logic [FAULT_W-1:0] fault_cnt;
  } lru_stat_t;

endpackage

// ----- hw/rtl/lru_req_if.sv -----
interface lru_req_if #(
  parameter int PAGE_BITS = 16
) ();
  logic                 valid;
  logic                 ready;
  logic [PAGE_BITS-1:0] page;

  modport source (output valid, output page, input ready);
  modport sink (input valid, input page, output ready);
endinterface

// ----- hw/rtl/lru_rsp_if.sv -----
interface lru_rsp_if #(
  parameter int PAGE_BITS = 16
) ();
  logic                              valid;
  logic                              ready;
  logic                              hit;
  logic [lru_pkg::FRAME_IDX_W-1:0]   frame_index;
  logic                              evicted_valid;
  logic [PAGE_BITS-1:0]              evicted_page;
  logic [lru_pkg::FAULT_W-1:0]       fault_count;

  modport source (
    output valid, output hit, output frame_index, output evicted_valid,
    output evicted_page, output fault_count, input ready
  );
  modport sink (
    input valid, input hit, input frame_index, input evicted_valid,
    input evicted_page, input fault_count, output ready
  );
endinterface

// ----- hw/rtl/lru_page_replacement.sv -----
// channel   dir  handshake              payload
// req_i     in   valid/ready            page
// rsp_o     out  valid/ready            hit, frame_index, evicted_valid,
//                                       evicted_page, fault_count
// cfg       in   cfg_we_i (no ready)    cfg_wdata_i = frame count
//
// a reference passes through these steps in the back end, n being the active frame count:
//   pick the beat from the queue, scan the n active frames one by one through the
//   single read port of the page ram, then update ranks and load the result
// reset clears frame valid bits, ranks, fill count and fault counter at once
// a two-beat queue lets requests land while the back end is scanning
// a result waiting in the output register stalls only the rank update
module lru_page_replacement #(
  parameter int FRAMES    = 8,
  parameter int PAGE_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  lru_req_if.sink                   req_i,
  lru_rsp_if.source                 rsp_o,
  input  logic                      cfg_we_i,
  input  logic [lru_pkg::CFG_W-1:0] cfg_wdata_i
);
  import lru_pkg::*;

  // frame count register, clamped later in the back end
  logic [CFG_W-1:0]     frame_count_q;

  // queue head between front and back
  logic                 q_valid;
  logic [PAGE_BITS-1:0] q_page;
  logic                 q_pop;

  lru_stat_t            stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_count_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      frame_count_q <= cfg_wdata_i;
    end
  end

  // front: takes request beats into a short queue
  lru_front #(
    .PAGE_BITS(PAGE_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req_i),
    .q_valid_o(q_valid),
    .q_page_o (q_page),
    .q_pop_i  (q_pop)
  );

  // back: frame scan, lru choice, rank update and result register
  lru_back #(
    .FRAMES   (FRAMES),
    .PAGE_BITS(PAGE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_frames_i(frame_count_q),
    .q_valid_i   (q_valid),
    .q_page_i    (q_page),
    .q_pop_o     (q_pop),
    .rsp_o       (rsp_o),
    .stat_o      (stat)
  );

`ifndef ASSERT_OFF
  // a hit never evicts anything
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> !(rsp_o.hit && rsp_o.evicted_valid))
    else $error("hit reported together with an eviction");

  // a fault beat always carries a non-zero fault count
  a_fault_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && !rsp_o.hit) |-> (rsp_o.fault_count != '0))
    else $error("fault reported with zero fault count");

  // the fault counter never goes backwards
  a_fault_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (stat.fault_cnt >= $past(stat.fault_cnt)))
    else $error("fault counter decreased");

  // finishing a reference always leaves a result in the output register
  a_done_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(stat.busy) |-> rsp_o.valid)
    else $error("reference finished without a result");
`endif

endmodule

// ----- hw/rtl/lru_ram.sv -----
module lru_ram #(
  parameter int WIDTH  = 16,
  parameter int DEPTH  = 8,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/lru_front.sv -----
module lru_front #(
  parameter int PAGE_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  lru_req_if.sink              req_i,
  output logic                 q_valid_o,
  output logic [PAGE_BITS-1:0] q_page_o,
  input  logic                 q_pop_i
);

  localparam int Q_DEPTH = 2;
  localparam int Q_CNT_W = 2;

  logic [PAGE_BITS-1:0] page_q [Q_DEPTH];
  logic                 wr_ptr_q, wr_ptr_d;
  logic                 rd_ptr_q, rd_ptr_d;
  logic [Q_CNT_W-1:0]   cnt_q, cnt_d;
  logic                 push, pop;

  assign req_i.ready = (cnt_q != Q_CNT_W'(Q_DEPTH));
  assign push        = req_i.valid && req_i.ready;
  assign pop         = q_pop_i && (cnt_q != '0);

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      page_q[wr_ptr_q] <= req_i.page;
    end
  end

  assign q_valid_o = (cnt_q != '0);
  assign q_page_o  = page_q[rd_ptr_q];

endmodule

// ----- hw/rtl/lru_back.sv -----
module lru_back #(
  parameter int FRAMES    = 8,
  parameter int PAGE_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [lru_pkg::CFG_W-1:0] cfg_frames_i,
  input  logic                      q_valid_i,
  input  logic [PAGE_BITS-1:0]      q_page_i,
  output logic                      q_pop_o,
  lru_rsp_if.source                 rsp_o,
  output lru_pkg::lru_stat_t        stat_o
);
  import lru_pkg::*;

  localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W = $clog2(FRAMES + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;

  logic [1:0]           state_q, state_d;
  logic [PAGE_BITS-1:0] page_q, page_d;
  logic [CNT_W-1:0]     rd_cnt_q, rd_cnt_d;
  logic                 chk_vld_q, chk_vld_d;
  logic                 chk_last_q, chk_last_d;
  logic [IDX_W-1:0]     chk_idx_q, chk_idx_d;
  logic                 hit_q, hit_d;
  logic [IDX_W-1:0]     hit_idx_q, hit_idx_d;
  logic                 best_fnd_q, best_fnd_d;
  logic [IDX_W-1:0]     best_idx_q, best_idx_d;
  logic [IDX_W-1:0]     best_rank_q, best_rank_d;
  logic [PAGE_BITS-1:0] best_page_q, best_page_d;
  logic [FRAMES-1:0]    valid_q, valid_d;
  logic [IDX_W-1:0]     rank_q [FRAMES];
  logic [IDX_W-1:0]     rank_d [FRAMES];
  logic [CNT_W-1:0]     filled_q, filled_d;
  logic [FAULT_W-1:0]   faults_q, faults_d;

  logic                   out_vld_q, out_vld_d;
  logic                   out_hit_q, out_hit_d;
  logic [FRAME_IDX_W-1:0] out_frame_q, out_frame_d;
  logic                   out_ev_q, out_ev_d;
  logic [PAGE_BITS-1:0]   out_ev_page_q, out_ev_page_d;
  logic [FAULT_W-1:0]     out_faults_q, out_faults_d;

  logic [CNT_W-1:0]     n_act;
  logic                 we;
  logic [IDX_W-1:0]     tgt;
  logic                 fill;
  logic                 can_out;
  logic [IDX_W-1:0]     chk_rank;
  logic [IDX_W-1:0]     tgt_rank;
  logic [PAGE_BITS-1:0] rdata;

  // active frame count, clamped to 1..FRAMES
  always_comb begin
    if (cfg_frames_i == '0) begin
      n_act = CNT_W'(1);
    end else if (32'(cfg_frames_i) > FRAMES) begin
      n_act = CNT_W'(FRAMES);
    end else begin
      n_act = CNT_W'(cfg_frames_i);
    end
  end

  lru_ram #(
    .WIDTH (PAGE_BITS),
    .DEPTH (FRAMES),
    .ADDR_W(IDX_W)
  ) u_page_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(tgt),
    .wdata_i(page_q),
    .raddr_i(rd_cnt_q[IDX_W-1:0]),
    .rdata_o(rdata)
  );

  assign can_out  = !out_vld_q || rsp_o.ready;
  assign fill     = !hit_q && (filled_q < n_act);
  assign tgt      = hit_q ? hit_idx_q : (fill ? filled_q[IDX_W-1:0] : best_idx_q);
  assign chk_rank = rank_q[chk_idx_q];
  assign tgt_rank = rank_q[tgt];
  assign we       = (state_q == ST_UPD) && can_out && !hit_q;

  always_comb begin
    state_d       = state_q;
    page_d        = page_q;
    rd_cnt_d      = rd_cnt_q;
    chk_vld_d     = 1'b0;
    chk_last_d    = 1'b0;
    chk_idx_d     = chk_idx_q;
    hit_d         = hit_q;
    hit_idx_d     = hit_idx_q;
    best_fnd_d    = best_fnd_q;
    best_idx_d    = best_idx_q;
    best_rank_d   = best_rank_q;
    best_page_d   = best_page_q;
    valid_d       = valid_q;
    rank_d        = rank_q;
    filled_d      = filled_q;
    faults_d      = faults_q;
    q_pop_o       = 1'b0;
    out_vld_d     = out_vld_q && !rsp_o.ready;
    out_hit_d     = out_hit_q;
    out_frame_d   = out_frame_q;
    out_ev_d      = out_ev_q;
    out_ev_page_d = out_ev_page_q;
    out_faults_d  = out_faults_q;

    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o    = 1'b1;
          page_d     = q_page_i;
          rd_cnt_d   = '0;
          hit_d      = 1'b0;
          best_fnd_d = 1'b0;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // issue one ram read per cycle
        if (rd_cnt_q < n_act) begin
          chk_vld_d  = 1'b1;
          chk_idx_d  = rd_cnt_q[IDX_W-1:0];
          chk_last_d = (rd_cnt_q == n_act - 1'b1);
          rd_cnt_d   = rd_cnt_q + 1'b1;
        end
        // compare the frame read in the previous cycle
        if (chk_vld_q) begin
          if (valid_q[chk_idx_q] && !hit_q && (rdata == page_q)) begin
            hit_d     = 1'b1;
            hit_idx_d = chk_idx_q;
          end
          if (valid_q[chk_idx_q] && (!best_fnd_q || (chk_rank > best_rank_q))) begin
            best_fnd_d  = 1'b1;
            best_idx_d  = chk_idx_q;
            best_rank_d = chk_rank;
            best_page_d = rdata;
          end
          if (chk_last_q) begin
            state_d = ST_UPD;
          end
        end
      end
      ST_UPD: begin
        if (can_out) begin
          for (int i = 0; i < FRAMES; i++) begin
            if (fill) begin
              if (valid_q[i]) begin
                rank_d[i] = rank_q[i] + 1'b1;
              end
            end else if ((IDX_W'(i) != tgt) && valid_q[i] && (rank_q[i] < tgt_rank)) begin
              rank_d[i] = rank_q[i] + 1'b1;
            end
          end
          rank_d[tgt]  = '0;
          valid_d[tgt] = 1'b1;
          if (fill) begin
            filled_d = filled_q + 1'b1;
          end
          if (!hit_q && (faults_q != '1)) begin
            faults_d = faults_q + 1'b1;
          end
          out_vld_d     = 1'b1;
          out_hit_d     = hit_q;
          out_frame_d   = FRAME_IDX_W'(tgt);
          out_ev_d      = !hit_q && !fill;
          out_ev_page_d = (!hit_q && !fill) ? best_page_q : '0;
          out_faults_d  = faults_d;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      chk_vld_q <= 1'b0;
      valid_q   <= '0;
      for (int i = 0; i < FRAMES; i++) begin
        rank_q[i] <= '0;
      end
      filled_q  <= '0;
      faults_q  <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      chk_vld_q <= chk_vld_d;
      valid_q   <= valid_d;
      rank_q    <= rank_d;
      filled_q  <= filled_d;
      faults_q  <= faults_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q        <= page_d;
    rd_cnt_q      <= rd_cnt_d;
    chk_last_q    <= chk_last_d;
    chk_idx_q     <= chk_idx_d;
    hit_q         <= hit_d;
    hit_idx_q     <= hit_idx_d;
    best_fnd_q    <= best_fnd_d;
    best_idx_q    <= best_idx_d;
    best_rank_q   <= best_rank_d;
    best_page_q   <= best_page_d;
    out_hit_q     <= out_hit_d;
    out_frame_q   <= out_frame_d;
    out_ev_q      <= out_ev_d;
    out_ev_page_q <= out_ev_page_d;
    out_faults_q  <= out_faults_d;
  end

  assign rsp_o.valid         = out_vld_q;
  assign rsp_o.hit           = out_hit_q;
  assign rsp_o.frame_index   = out_frame_q;
  assign rsp_o.evicted_valid = out_ev_q;
  assign rsp_o.evicted_page  = out_ev_page_q;
  assign rsp_o.fault_count   = out_faults_q;

  assign stat_o.busy      = (state_q != ST_IDLE);
  assign stat_o.fault_cnt = faults_q;

endmodule
